[rtl/bbpp_pkg.sv]
`default_nettype none

package bbpp_pkg;

   localparam int COORD_W     = 32;
   localparam int PARAM_W     = 17;
   localparam int IDX_W       = 4;
   localparam int NUM_POINTS  = 16;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 96;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   // one control point as stored: x in the low word
   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   // tag that travels with each read of the control point memory
   typedef struct packed {
      logic       valid;
      logic [1:0] row;
      logic [1:0] col;
   } tag_type;

endpackage

`default_nettype wire

[rtl/bicubic_bezier_patch_point.sv]
// Bicubic Bezier patch point evaluator. Holds the sixteen control points of
// one patch (signed Q16.16 x, y, z) in a 16-entry memory and evaluates
// P(u,v) with cubic Bernstein weights, rounding to nearest after the row and
// after the column stage. A load (tuser = 0) writes one point and returns
// nothing. An evaluation (tuser = 1) returns one transfer after these steps
// in order: the weight units (8 steps on one shared multiplier each, u and v
// in parallel, plus the hand-off to the sweep), the memory sweep (one control
// point read per cycle on the single read port), 6 lane pipeline stages, the
// hold state and the output register. Input is ready again once the result
// is in the output register; a result left waiting in the output register
// holds the next finished point in the hold state, and the input stays
// stalled until it can move. One item is worked on at a time; the next item
// is accepted while a result waits to be taken. Parameters above one are
// saturated to one. Evaluating before all sixteen slots have been loaded
// reads unwritten memory and gives undefined values.
`default_nettype none

module bicubic_bezier_patch_point #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // point_index[3:0], coord_x[35:4], coord_y[67:36], coord_z[99:68],
   // u_param[116:100], v_param[133:117], zero pad[135:134]
   input  wire logic [bbpp_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // mode[0]
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // point_x[31:0], point_y[63:32], point_z[95:64]
   output logic [bbpp_pkg::RSP_TDATA_W-1:0]          rsp_tdata
);

   localparam int W = FRAC_BITS + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASIS,
      ST_SWEEP,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   state_type                             state_ff, state_in;
   logic [bbpp_pkg::IDX_W-1:0]            sweep_idx_ff, sweep_idx_in;
   bbpp_pkg::tag_type                     rd_tag_ff, rd_tag_in;
   logic                                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [bbpp_pkg::RSP_TDATA_W-1:0]      rsp_tdata_ff, rsp_tdata_in;

   logic                                  req_xfer;
   logic                                  load_wr;
   logic                                  eval_start;
   bbpp_pkg::point_type                   wr_point;
   bbpp_pkg::point_type                   rd_point;
   logic                                  u_done, v_done, basis_done;
   logic [3:0][W-1:0]                     wu, wv;
   logic [W-1:0]                          wu_sel;
   logic                                  x_done, y_done, z_done;
   logic signed [bbpp_pkg::COORD_W-1:0]   x_res, y_res, z_res;
   logic                                  out_free;

   // input unpacking
   assign req_xfer   = req_tvalid && req_tready;
   assign load_wr    = req_xfer && (req_tuser == bbpp_pkg::MODE_LOAD);
   assign eval_start = req_xfer && (req_tuser == bbpp_pkg::MODE_EVAL);
   assign wr_point.x = req_tdata[35:4];
   assign wr_point.y = req_tdata[67:36];
   assign wr_point.z = req_tdata[99:68];

   bbpp_ctrl_mem u_mem (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_tdata[3:0]),
      .wr_data (wr_point),
      .rd_addr (sweep_idx_ff),
      .rd_data (rd_point)
   );

   bbpp_basis #(.FRAC_BITS(FRAC_BITS)) u_basis_u (
      .clock   (clock),
      .reset   (reset),
      .start   (eval_start),
      .t_raw   (req_tdata[116:100]),
      .done    (u_done),
      .weights (wu)
   );

   bbpp_basis #(.FRAC_BITS(FRAC_BITS)) u_basis_v (
      .clock   (clock),
      .reset   (reset),
      .start   (eval_start),
      .t_raw   (req_tdata[133:117]),
      .done    (v_done),
      .weights (wv)
   );

   assign basis_done = u_done && v_done;

   // column weight lines up with the read data
   assign wu_sel = wu[rd_tag_ff.col];

   bbpp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .in_coord (rd_point.x),
      .in_wu    (wu_sel),
      .wv       (wv),
      .done     (x_done),
      .result   (x_res)
   );

   bbpp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .in_coord (rd_point.y),
      .in_wu    (wu_sel),
      .wv       (wv),
      .done     (y_done),
      .result   (y_res)
   );

   bbpp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (rd_tag_ff),
      .in_coord (rd_point.z),
      .in_wu    (wu_sel),
      .wv       (wv),
      .done     (z_done),
      .result   (z_res)
   );

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      sweep_idx_in  = sweep_idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rd_tag_in.valid = (state_ff == ST_SWEEP);
      rd_tag_in.row   = sweep_idx_ff[3:2];
      rd_tag_in.col   = sweep_idx_ff[1:0];
      case (state_ff)
         ST_IDLE: begin
            if (eval_start) begin
               state_in = ST_BASIS;
            end
         end
         ST_BASIS: begin
            sweep_idx_in = '0;
            if (basis_done) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            sweep_idx_in = sweep_idx_ff + bbpp_pkg::IDX_W'(1);
            if (sweep_idx_ff == bbpp_pkg::IDX_W'(bbpp_pkg::NUM_POINTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (x_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {z_res, y_res, x_res};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sweep_idx_ff  <= '0;
         rd_tag_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_idx_ff  <= sweep_idx_in;
         rd_tag_ff     <= rd_tag_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // lanes run in lockstep
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (x_done == y_done) && (x_done == z_done))
      else $error("coordinate lanes out of step");

   // result pops out of the lanes only while draining
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      x_done |-> (state_ff == ST_DRAIN))
      else $error("lane result outside drain");

   // weights finish only while waiting for them
   a_basis_in_state: assert property (@(posedge clock) disable iff (reset)
      basis_done |-> (state_ff == ST_BASIS))
      else $error("basis finished outside basis state");

   // memory reads happen only during the sweep
   a_reads_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_tag_ff.valid |-> ($past(state_ff) == ST_SWEEP))
      else $error("read tag outside sweep");

   // a finished point reaches the output register on the next cycle when free
   a_hold_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) && out_free |=> rsp_tvalid_ff && (state_ff == ST_IDLE))
      else $error("result not delivered from hold");

endmodule

`default_nettype wire

[rtl/bbpp_ctrl_mem.sv]
`default_nettype none

module bbpp_ctrl_mem (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [bbpp_pkg::IDX_W-1:0]          wr_addr,
   input  wire bbpp_pkg::point_type                 wr_data,
   input  wire logic [bbpp_pkg::IDX_W-1:0]          rd_addr,
   output bbpp_pkg::point_type                      rd_data
);

   bbpp_pkg::point_type mem [bbpp_pkg::NUM_POINTS];
   bbpp_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/bbpp_basis.sv]
`default_nettype none

// Cubic Bernstein weights for one parameter, one shared multiplier,
// eight steps. Weights are clamped so they sum to exactly one.
module bbpp_basis #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [bbpp_pkg::PARAM_W-1:0]        t_raw,
   output logic                                     done,
   output logic [3:0][FRAC_BITS:0]                  weights
);

   localparam int W  = FRAC_BITS + 1;
   localparam int PW = 2 * W;
   localparam int CW = (W > bbpp_pkg::PARAM_W) ? W : bbpp_pkg::PARAM_W;
   localparam logic [W-1:0]    ONE    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PW+1:0]   HALF   = (PW + 2)'(2 ** (FRAC_BITS - 1));

   // step codes; steps SS to RND3 each round the product of the step before
   localparam logic [2:0] STEP_TT   = 3'd0;  // t*t
   localparam logic [2:0] STEP_SS   = 3'd1;  // s*s,   round tt
   localparam logic [2:0] STEP_TS   = 3'd2;  // t*s,   round ss
   localparam logic [2:0] STEP_T3   = 3'd3;  // tt*t,  round ts
   localparam logic [2:0] STEP_S3   = 3'd4;  // ss*s,  round t3
   localparam logic [2:0] STEP_B1   = 3'd5;  // ts*s,  round s3
   localparam logic [2:0] STEP_RND3 = 3'd6;  // round 3*ts*s
   localparam logic [2:0] STEP_LAST = 3'd7;  // clamp

   logic            busy_ff, busy_in;
   logic [2:0]      step_ff, step_in;
   logic            done_ff, done_in;
   logic [W-1:0]    t_ff, s_ff;
   logic [W-1:0]    tt_ff, ss_ff, ts_ff, t3_ff, s3_ff, b1_ff;
   logic [PW-1:0]   prod_ff, prod_in;
   logic [3:0][W-1:0] w_ff;

   logic [CW-1:0]   t_ext;
   logic [W-1:0]    t_sat;
   logic [W-1:0]    mul_a, mul_b;
   logic [PW+1:0]   rnd_sum, rnd3_sum;
   logic [W-1:0]    rnd_val, rnd3_val;
   logic [W-1:0]    t3c, rem0, s3c, rem1, b1c;

   assign t_ext = CW'(t_raw);
   assign t_sat = (t_ext > CW'(ONE)) ? ONE : t_ext[W-1:0];

   always_comb begin
      case (step_ff)
         STEP_TT: begin mul_a = t_ff;  mul_b = t_ff; end
         STEP_SS: begin mul_a = s_ff;  mul_b = s_ff; end
         STEP_TS: begin mul_a = t_ff;  mul_b = s_ff; end
         STEP_T3: begin mul_a = tt_ff; mul_b = t_ff; end
         STEP_S3: begin mul_a = ss_ff; mul_b = s_ff; end
         STEP_B1: begin mul_a = ts_ff; mul_b = s_ff; end
         default: begin mul_a = '0;    mul_b = '0;   end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign rnd_sum  = {2'b00, prod_ff} + HALF;
   assign rnd3_sum = {2'b00, prod_ff} + {1'b0, prod_ff, 1'b0} + HALF;
   assign rnd_val  = rnd_sum[FRAC_BITS +: W];
   assign rnd3_val = rnd3_sum[FRAC_BITS +: W];

   // clamp so that all weights are non-negative and sum to one
   assign t3c  = (t3_ff > ONE) ? ONE : t3_ff;
   assign rem0 = ONE - t3c;
   assign s3c  = (s3_ff > rem0) ? rem0 : s3_ff;
   assign rem1 = rem0 - s3c;
   assign b1c  = (b1_ff > rem1) ? rem1 : b1_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_TT;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
      done_in = busy_ff && (step_ff == STEP_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_TT;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         t_ff <= t_sat;
         s_ff <= ONE - t_sat;
      end
      prod_ff <= prod_in;
      if (busy_ff) begin
         case (step_ff)
            STEP_SS:   tt_ff <= rnd_val;
            STEP_TS:   ss_ff <= rnd_val;
            STEP_T3:   ts_ff <= rnd_val;
            STEP_S3:   t3_ff <= rnd_val;
            STEP_B1:   s3_ff <= rnd_val;
            STEP_RND3: b1_ff <= rnd3_val;
            STEP_LAST: begin
               w_ff[0] <= s3c;
               w_ff[1] <= b1c;
               w_ff[2] <= rem1 - b1c;
               w_ff[3] <= t3c;
            end
            default: ;
         endcase
      end
   end

   assign done    = done_ff;
   assign weights = w_ff;

endmodule

`default_nettype wire

[rtl/bbpp_lane.sv]
`default_nettype none

// One coordinate: row sums of wu*P, rounded, then column sum of wv*row,
// rounded. Six register stages from read data to result.
module bbpp_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bbpp_pkg::tag_type                     in_tag,
   input  wire logic signed [bbpp_pkg::COORD_W-1:0]   in_coord,
   input  wire logic [FRAC_BITS:0]                    in_wu,
   input  wire logic [3:0][FRAC_BITS:0]               wv,
   output logic                                       done,
   output logic signed [bbpp_pkg::COORD_W-1:0]        result
);

   localparam int W  = FRAC_BITS + 1;
   localparam int MW = bbpp_pkg::COORD_W + W + 1;
   localparam int RW = MW + 2;
   localparam logic signed [RW-1:0] HALF = RW'(2 ** (FRAC_BITS - 1));

   bbpp_pkg::tag_type                    t1_ff, t2_ff;
   logic signed [MW-1:0]                 mprod_ff;
   logic signed [RW-1:0]                 row_ff, row_in, row_rnd;
   logic                                 r_valid_ff;
   logic [1:0]                           r_row_ff;
   logic signed [bbpp_pkg::COORD_W-1:0]  r_ff;
   logic                                 c_valid_ff;
   logic [1:0]                           c_row_ff;
   logic signed [MW-1:0]                 cprod_ff;
   logic signed [RW-1:0]                 acc_ff, acc_in, acc_rnd;
   logic                                 a_done_ff;
   logic                                 done_ff;
   logic signed [bbpp_pkg::COORD_W-1:0]  result_ff;

   assign row_in  = (t1_ff.col == 2'd0) ? RW'(mprod_ff) : row_ff + RW'(mprod_ff);
   assign row_rnd = (row_ff + HALF) >>> FRAC_BITS;
   assign acc_in  = (c_row_ff == 2'd0) ? RW'(cprod_ff) : acc_ff + RW'(cprod_ff);
   assign acc_rnd = (acc_ff + HALF) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff      <= '0;
         t2_ff      <= '0;
         r_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         a_done_ff  <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         t1_ff      <= in_tag;
         t2_ff      <= t1_ff;
         r_valid_ff <= t2_ff.valid && (t2_ff.col == 2'd3);
         c_valid_ff <= r_valid_ff;
         a_done_ff  <= c_valid_ff && (c_row_ff == 2'd3);
         done_ff    <= a_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      mprod_ff <= in_coord * $signed({1'b0, in_wu});
      if (t1_ff.valid) begin
         row_ff <= row_in;
      end
      r_row_ff <= t2_ff.row;
      r_ff     <= row_rnd[bbpp_pkg::COORD_W-1:0];
      c_row_ff <= r_row_ff;
      cprod_ff <= r_ff * $signed({1'b0, wv[r_row_ff]});
      if (c_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (a_done_ff) begin
         result_ff <= acc_rnd[bbpp_pkg::COORD_W-1:0];
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire
